>>> design/totp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TOTP package
// Shared constants and types for the TOTP HMAC-SHA1 code generator.
// ----------------------------------------------------------------------------
package totp_pkg;

   localparam int KEY_WORDS = 8;
   localparam int KEY_IDX_W = 3;
   localparam int CSR_IDX_W = 8;
   localparam int STEP_SECONDS = 30;
   localparam int CODE_MOD = 1000000;
   localparam int CODE_W = 20;

   // Reciprocals for division by the step on 16-bit digits and for reducing
   // a 31-bit value by the code modulus.
   localparam int DIV_SHIFT = 26;
   localparam logic [21:0] DIV_RECIP =
      22'(((64'd1 << DIV_SHIFT) + 64'(STEP_SECONDS) - 64'd1) / 64'(STEP_SECONDS));
   localparam int MOD_SHIFT = 51;
   localparam logic [31:0] MOD_RECIP =
      32'(((64'd1 << MOD_SHIFT) + 64'(CODE_MOD) - 64'd1) / 64'(CODE_MOD));

   localparam logic [31:0] IPAD_WORD = 32'h36363636;
   localparam logic [31:0] OPAD_WORD = 32'h5C5C5C5C;
   localparam logic [31:0] PAD_ONE = 32'h80000000;
   localparam logic [31:0] INNER_LEN_BITS = 32'd576;
   localparam logic [31:0] OUTER_LEN_BITS = 32'd672;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   // Block selector for the four compressions of one HMAC.
   typedef enum logic [1:0] {
      BLK_INNER_KEY,
      BLK_INNER_MSG,
      BLK_OUTER_KEY,
      BLK_OUTER_MSG
   } blk_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_time;
      logic        div_step;
      logic        load_block;
      blk_sel_type blk_sel;
      logic        round_step;
      logic        add_hash;
      logic        save_inner;
      logic        truncate;
      logic        mod_mul;
      logic        mod_sub;
      logic        post;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic round_last;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> design/totp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TOTP channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface totp_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] unix_seconds;
   modport source (output valid, output unix_seconds, input ready);
   modport sink (input valid, input unix_seconds, output ready);
endinterface

interface totp_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] otp_code;
   modport source (output valid, output otp_code, input ready);
   modport sink (input valid, input otp_code, output ready);
endinterface

interface totp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/totp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TOTP datapath
// Time divider, SHA-1 round unit, hash registers, truncation and reduction.
// ----------------------------------------------------------------------------
module totp_datapath
   import totp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] unix_seconds,
   input  wire logic [63:0] key_words [KEY_WORDS],
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   output logic [CODE_W-1:0] code
);

   logic [63:0] quot_ff, quot_in;
   logic [4:0]  rem_ff, rem_in;
   logic [1:0]  div_cnt_ff, div_cnt_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] ih_ff [5];
   logic [31:0] ih_in [5];
   logic [6:0]  rnd_ff, rnd_in;
   logic [30:0] bin_ff, bin_in;
   logic [11:0] mq_ff, mq_in;
   logic [CODE_W-1:0] code_ff, code_in;

   logic [31:0] blk [16];
   logic [31:0] pad;
   logic [31:0] f, k, t, wnew;
   logic [20:0] dividend;
   logic [15:0] dq;
   logic [4:0]  drem;
   logic [159:0] mac;
   logic [3:0]  off;
   logic [30:0] sel;
   logic [11:0] mq;
   logic [30:0] mred;

   always_comb begin
      pad = (cmd.blk_sel == BLK_OUTER_KEY) ? OPAD_WORD : IPAD_WORD;
      for (int i = 0; i < 16; i++) begin
         blk[i] = '0;
      end
      unique case (cmd.blk_sel)
         BLK_INNER_KEY, BLK_OUTER_KEY: begin
            for (int i = 0; i < KEY_WORDS; i++) begin
               blk[2*i] = key_words[i][63:32] ^ pad;
               blk[2*i+1] = key_words[i][31:0] ^ pad;
            end
         end
         BLK_INNER_MSG: begin
            blk[0] = quot_ff[63:32];
            blk[1] = quot_ff[31:0];
            blk[2] = PAD_ONE;
            blk[15] = INNER_LEN_BITS;
         end
         default: begin
            for (int i = 0; i < 5; i++) begin
               blk[i] = ih_ff[i];
            end
            blk[5] = PAD_ONE;
            blk[15] = OUTER_LEN_BITS;
         end
      endcase
   end

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K_ROUND0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K_ROUND1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K_ROUND2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K_ROUND3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_ff[0];
      wnew = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wnew = {wnew[30:0], wnew[31]};
   end

   // Division by the time step, one 16-bit digit a cycle by reciprocal
   // multiplication; the partial remainder is always below the step.
   always_comb begin
      dividend = {rem_ff, quot_ff[63:48]};
      dq = 16'((42'(dividend) * 42'(DIV_RECIP)) >> DIV_SHIFT);
      drem = 5'(dividend - 21'(dq) * 21'(STEP_SECONDS));
   end

   always_comb begin
      mac = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
      off = mac[3:0];
      sel = mac[158 - 8*off -: 31];
      mq = 12'((63'(bin_ff) * 63'(MOD_RECIP)) >> MOD_SHIFT);
      mred = bin_ff - 31'(mq_ff) * 31'(CODE_MOD);
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff;
      ih_in = ih_ff;
      rnd_in = rnd_ff;
      bin_in = bin_ff;
      mq_in = mq_ff;
      code_in = code_ff;
      if (cmd.load_time) begin
         quot_in = unix_seconds;
         rem_in = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = drem;
         quot_in = {quot_ff[47:0], dq};
         div_cnt_in = div_cnt_ff + 2'd1;
      end
      if (cmd.load_block) begin
         w_in = blk;
         rnd_in = '0;
         if (cmd.blk_sel == BLK_INNER_KEY || cmd.blk_sel == BLK_OUTER_KEY) begin
            h_in[0] = H0_INIT; h_in[1] = H1_INIT; h_in[2] = H2_INIT;
            h_in[3] = H3_INIT; h_in[4] = H4_INIT;
            a_in = H0_INIT; b_in = H1_INIT; c_in = H2_INIT;
            d_in = H3_INIT; e_in = H4_INIT;
         end else begin
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2];
            d_in = h_ff[3]; e_in = h_ff[4];
         end
      end
      if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = wnew;
         e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]};
         b_in = a_ff; a_in = t;
         rnd_in = rnd_ff + 7'd1;
      end
      if (cmd.add_hash) begin
         h_in[0] = h_ff[0] + a_ff; h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff; h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
         a_in = h_ff[0] + a_ff; b_in = h_ff[1] + b_ff;
         c_in = h_ff[2] + c_ff; d_in = h_ff[3] + d_ff;
         e_in = h_ff[4] + e_ff;
      end
      if (cmd.save_inner) begin
         ih_in = h_ff;
      end
      if (cmd.truncate) begin
         bin_in = sel;
      end
      if (cmd.mod_mul) begin
         mq_in = mq;
      end
      if (cmd.mod_sub) begin
         bin_in = mred;
      end
      if (cmd.post) begin
         code_in = bin_ff[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      h_ff <= h_in;
      ih_ff <= ih_in;
      bin_ff <= bin_in;
      mq_ff <= mq_in;
      code_ff <= code_in;
      if (reset) begin
         div_cnt_ff <= '0;
         rnd_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
         rnd_ff <= rnd_in;
      end
   end

   assign stat.div_done = (div_cnt_ff == 2'd3);
   assign stat.round_last = (rnd_ff == 7'd79);
   assign code = code_ff;

`ifndef SYNTHESIS
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= 7'd80) else $error("round counter out of range");
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.mod_sub) |-> bin_ff < 31'(CODE_MOD))
      else $error("code not reduced");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < 5'(STEP_SECONDS))
      else $error("division remainder out of range");
`endif

endmodule
`default_nettype wire

>>> design/totp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TOTP controller
// Sequences division, four SHA-1 compressions, truncation and reduction.
// ----------------------------------------------------------------------------
module totp_ctrl
   import totp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_ADD, ST_TRUNC, ST_MOD_MUL,
      ST_MOD_SUB, ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   blk_sel_type blk_ff, blk_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      blk_in = blk_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      cmd.blk_sel = blk_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_time = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               blk_in = BLK_INNER_KEY;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_block = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (stat.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            state_in = ST_LOAD;
            unique case (blk_ff)
               BLK_INNER_KEY: blk_in = BLK_INNER_MSG;
               BLK_INNER_MSG: blk_in = BLK_OUTER_KEY;
               BLK_OUTER_KEY: blk_in = BLK_OUTER_MSG;
               default: state_in = ST_TRUNC;
            endcase
         end
         ST_TRUNC: begin
            cmd.truncate = 1'b1;
            state_in = ST_MOD_MUL;
         end
         ST_MOD_MUL: begin
            cmd.mod_mul = 1'b1;
            state_in = ST_MOD_SUB;
         end
         ST_MOD_SUB: begin
            cmd.mod_sub = 1'b1;
            state_in = ST_DONE;
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
      // The hash registers hold the inner digest in the cycle after its add.
      if (state_ff == ST_LOAD && blk_ff == BLK_OUTER_KEY) begin
         cmd.save_inner = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blk_ff <= BLK_INNER_KEY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         blk_ff <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DIV) else $error("bad start");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == ST_DONE && state_ff == ST_IDLE |-> rsp_valid)
      else $error("result lost");
`endif

endmodule
`default_nettype wire

>>> design/totp_hmac_sha1_code.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 code generator
// Six-digit time-based one-time password from a Unix time and a 64-byte key.
// ----------------------------------------------------------------------------
// A request carries a Unix time in seconds. The block divides it by 30,
// computes HMAC-SHA1 over the counter under the key in eight 64-bit
// registers and returns one response with the six-digit code.
// Register writes arrive on the csr channel and are always taken; an
// index above seven is ignored. Keys must be written while the block is
// idle; the block itself does not enforce this. After a request is
// accepted, it divides the time by 30 on 16-bit digits, runs four
// compressions on a single round unit, truncates, reduces the value
// and posts the code. One request is processed at a time. The response
// waits in an output register; a stalled receiver holds the block in its
// final state until the register is free.
// Reset clears the key registers and returns the block to idle.
// ----------------------------------------------------------------------------
module totp_hmac_sha1_code
   import totp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   totp_req_if.sink   req,
   totp_rsp_if.source rsp,
   totp_csr_if.sink   csr
);

   logic [63:0] key_ff [KEY_WORDS];
   logic [CODE_W-1:0] code;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr.valid && csr.index < CSR_IDX_W'(KEY_WORDS)) begin
         key_ff[csr.index[KEY_IDX_W-1:0]] <= csr.data;
      end
   end

   totp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   totp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .unix_seconds (req.unix_seconds),
      .key_words    (key_ff),
      .cmd          (cmd),
      .stat         (stat),
      .code         (code)
   );

   assign rsp.otp_code = code;

endmodule
`default_nettype wire

>>> tb/tb_totp_hmac_sha1_code.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 code generator testbench
// Drives Unix times and key writes into the code generator and compares every
// six-digit code with one computed by an independent HMAC-SHA1 predictor.
// ----------------------------------------------------------------------------
module tb_totp_hmac_sha1_code;
   import totp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   class code_scoreboard;
      logic [63:0] key [KEY_WORDS];
      logic [19:0] pending [$];
      int errors;

      function new();
         foreach (key[i]) key[i] = '0;
         errors = 0;
      endfunction

      function logic [31:0] rol(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void sha1_block(ref logic [31:0] h [5], input logic [31:0] blk [16]);
         logic [31:0] w [80];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int i = 0; i < 16; i++) w[i] = blk[i];
         for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
         a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
         for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d); k = K_ROUND0;
            end else if (i < 40) begin
               f = b ^ c ^ d; k = K_ROUND1;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d); k = K_ROUND2;
            end else begin
               f = b ^ c ^ d; k = K_ROUND3;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
         end
         h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
      endfunction

      function void hash_start(ref logic [31:0] h [5], input logic [31:0] pad);
         logic [31:0] blk [16];
         h[0] = H0_INIT; h[1] = H1_INIT; h[2] = H2_INIT; h[3] = H3_INIT; h[4] = H4_INIT;
         for (int i = 0; i < KEY_WORDS; i++) begin
            blk[2*i] = key[i][63:32] ^ pad;
            blk[2*i+1] = key[i][31:0] ^ pad;
         end
         sha1_block(h, blk);
      endfunction

      function logic [19:0] totp_code(logic [63:0] secs);
         logic [63:0] ctr;
         logic [31:0] hi [5];
         logic [31:0] ho [5];
         logic [31:0] blk [16];
         logic [159:0] mac;
         logic [31:0] bin;
         int off;
         ctr = secs / 64'd30;
         hash_start(hi, IPAD_WORD);
         foreach (blk[i]) blk[i] = '0;
         blk[0] = ctr[63:32]; blk[1] = ctr[31:0]; blk[2] = PAD_ONE; blk[15] = INNER_LEN_BITS;
         sha1_block(hi, blk);
         hash_start(ho, OPAD_WORD);
         foreach (blk[i]) blk[i] = '0;
         for (int i = 0; i < 5; i++) blk[i] = hi[i];
         blk[5] = PAD_ONE; blk[15] = OUTER_LEN_BITS;
         sha1_block(ho, blk);
         mac = {ho[0], ho[1], ho[2], ho[3], ho[4]};
         off = mac[3:0];
         bin = mac[159 - 8*off -: 32];
         bin[31] = 1'b0;
         return 20'(bin % CODE_MOD);
      endfunction

      function void note_request(logic [63:0] secs);
         pending.push_back(totp_code(secs));
      endfunction

      function void check_code(logic [19:0] got);
         logic [19:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected code: expected none, actual %0d", $time, got);
            errors++;
         end else begin
            want = pending.pop_front();
            if (want !== got) begin
               $display("%0t: otp_code mismatch: expected %0d, actual %0d", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   totp_req_if req ();
   totp_rsp_if rsp ();
   totp_csr_if csr ();

   totp_hmac_sha1_code DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   code_scoreboard board = new();
   bit quiet_mode = 1'b0;
   bit long_hold = 1'b0;
   bit burst_hold = 1'b0;
   int unsigned idle_cycles = 0;

   task automatic send_time(logic [63:0] secs, bit gaps);
      if (gaps && !quiet_mode && $urandom_range(3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.unix_seconds <= secs;
      do @(posedge clock); while (!req.ready);
      board.note_request(secs);
   endtask

   task automatic write_key(int idx, logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= 8'(idx);
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      if (idx < KEY_WORDS) board.key[idx] = value;
   endtask

   task automatic end_writes();
      csr.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_key(int mode);
      for (int i = 0; i < KEY_WORDS; i++) begin
         case (mode)
            0: write_key(i, '0);
            1: write_key(i, '1);
            2: write_key(i, (i < 3) ? {$urandom, $urandom} : 64'd0);
            default: write_key(i, {$urandom, $urandom});
         endcase
      end
      end_writes();
   endtask

   function automatic logic [63:0] random_time();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return 64'(1600000000 + $urandom_range(200000000));
         2: return {32'hFFFFFFFF, $urandom};
         default: return 64'($urandom_range(100));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || long_hold || burst_hold) begin
         rsp.ready <= 1'b0;
      end else if (quiet_mode) begin
         rsp.ready <= 1'b1;
      end else if ($urandom_range(7) == 0) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
      if (!reset && rsp.valid && rsp.ready) board.check_code(rsp.otp_code);
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (!reset && !quiet_mode && !long_hold && !burst_hold &&
             $urandom_range(40) == 0) begin
            burst = $urandom_range(15, 1);
            burst_hold = 1'b1;
            repeat (burst) @(posedge clock);
            burst_hold = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("tb_totp_hmac_sha1_code failed");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0; req.unix_seconds = '0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_time(64'd0, 0);
      send_time(64'd59, 0);
      wait_drained();
      write_key(9, '1);
      write_key(255, 64'h1234);
      end_writes();
      send_time(64'd29, 0);
      send_time('1, 0);
      wait_drained();
      load_key(1);
      send_time(64'd30, 0);
      send_time('1, 0);
      send_time(64'hAAAA_AAAA_AAAA_AAAA, 0);
      wait_drained();
      write_key(0, 64'h3132333435363738);
      write_key(1, 64'h3930313233343536);
      write_key(2, 64'h3738393000000000);
      for (int i = 3; i < KEY_WORDS; i++) write_key(i, '0);
      end_writes();
      send_time(64'd59, 0);
      send_time(64'd1111111109, 0);
      send_time(64'd1234567890, 0);
      send_time(64'd20000000000, 0);
      send_time(64'h5555_5555_5555_5555, 0);
      wait_drained();

      fork
         begin
            long_hold = 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_time(random_time(), 0);
      join
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         load_key(phase % 4);
         for (int n = 0; n < 115; n++) send_time(random_time(), 1);
         wait_drained();
      end

      quiet_mode = 1'b1;
      for (int n = 0; n < 60; n++) send_time(random_time(), 0);
      wait_drained();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_totp_hmac_sha1_code passed");
      end else begin
         $display("tb_totp_hmac_sha1_code failed");
      end
      $finish;
   end
endmodule
